/* design/swbl_pkg.sv */
// Package for the stop-and-wait block loader: operation and event codes,
// register map, sizing constants and the structs shared between modules.
// Depends on nothing.
package swbl_pkg;

  // Image blocks and flash pages; both sizes are powers of two.
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);

  // Field widths of the channels.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SIZE_W    = 20;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned REQ_HI_W  = 8;
  localparam int unsigned PAGES_W   = 13;
  localparam int unsigned BLOCK_W   = 17;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned RETRY_W   = 8;

  // Largest erase count the result field can carry.
  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] REG_FLASH_BASE    = 2'd2;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [RETRY_W-1:0] RETRY_RESET   = 8'd3;
  localparam logic [WORD_W-1:0]  BASE_RESET    = 32'd0;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_TICK     = 2'd1,
    OP_RESPONSE = 2'd2
  } swbl_op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_REQUEST = 3'd0,
    EV_WRITE   = 3'd1,
    EV_ERASE   = 3'd2,
    EV_DONE    = 3'd3,
    EV_ABORT   = 3'd4
  } swbl_event_e;

  // Register values seen by the loader engine.
  typedef struct packed {
    logic [TICKS_W-1:0] timeout_limit;
    logic [RETRY_W-1:0] retry_limit;
    logic [WORD_W-1:0]  flash_base;
  } swbl_cfg_t;

  // One input item.
  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SIZE_W-1:0]   image_size;
    logic [NIBBLE_W-1:0] reply_block_low;
    logic [WORD_W-1:0]   data_word0;
    logic [WORD_W-1:0]   data_word1;
    logic [WORD_W-1:0]   data_word2;
    logic [WORD_W-1:0]   data_word3;
  } swbl_item_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0]   event_kind;
    logic [REQ_HI_W-1:0] request_high;
    logic [NIBBLE_W-1:0] request_low;
    logic [WORD_W-1:0]   write_address;
    logic [WORD_W-1:0]   out_word0;
    logic [WORD_W-1:0]   out_word1;
    logic [WORD_W-1:0]   out_word2;
    logic [WORD_W-1:0]   out_word3;
    logic [PAGES_W-1:0]  erase_pages;
  } swbl_result_t;

endpackage

/* design/swbl_if.sv */
// Valid/ready channel interfaces for the block loader's item and result streams.
// Depends on swbl_pkg for field widths.

// Input item channel.
interface swbl_in_if;
  logic                             valid;
  logic                             ready;
  logic [swbl_pkg::OP_W-1:0]        operation;
  logic [swbl_pkg::SIZE_W-1:0]      image_size;
  logic [swbl_pkg::NIBBLE_W-1:0]    reply_block_low;
  logic [swbl_pkg::WORD_W-1:0]      data_word0;
  logic [swbl_pkg::WORD_W-1:0]      data_word1;
  logic [swbl_pkg::WORD_W-1:0]      data_word2;
  logic [swbl_pkg::WORD_W-1:0]      data_word3;

  modport source (
    output valid, operation, image_size, reply_block_low,
           data_word0, data_word1, data_word2, data_word3,
    input  ready
  );
  modport sink (
    input  valid, operation, image_size, reply_block_low,
           data_word0, data_word1, data_word2, data_word3,
    output ready
  );
endinterface

// Result channel.
interface swbl_out_if;
  logic                             valid;
  logic                             ready;
  logic [swbl_pkg::KIND_W-1:0]      event_kind;
  logic [swbl_pkg::REQ_HI_W-1:0]    request_high;
  logic [swbl_pkg::NIBBLE_W-1:0]    request_low;
  logic [swbl_pkg::WORD_W-1:0]      write_address;
  logic [swbl_pkg::WORD_W-1:0]      out_word0;
  logic [swbl_pkg::WORD_W-1:0]      out_word1;
  logic [swbl_pkg::WORD_W-1:0]      out_word2;
  logic [swbl_pkg::WORD_W-1:0]      out_word3;
  logic [swbl_pkg::PAGES_W-1:0]     erase_pages;

  modport source (
    output valid, event_kind, request_high, request_low, write_address,
           out_word0, out_word1, out_word2, out_word3, erase_pages,
    input  ready
  );
  modport sink (
    input  valid, event_kind, request_high, request_low, write_address,
           out_word0, out_word1, out_word2, out_word3, erase_pages,
    output ready
  );
endinterface

/* design/stop_and_wait_block_loader_core.sv */
// Top level of the stop-and-wait block loader: input register, engine, result
// register and configuration registers. Depends on swbl_pkg, swbl_if, swbl_cfg
// and swbl_engine.
//
//   Port      Dir   Kind          Carries
//   item_i    in    valid/ready   start, tick and block response items
//   result_o  out   valid/ready   request, flash write, erase, done, abort
//   APB       in    config write  timeout_limit, retry_limit, flash_base
//
// An item is held in the input register and its result, if any, goes into
// the result register when the engine steps; one item per cycle sustained
// while results drain. The engine steps when the result register is empty or
// being drained, so a stalled result holds back at most the one held item.
// Reset clears the protocol state and loads the register defaults.
module stop_and_wait_block_loader_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  swbl_in_if.sink                         item_i,
  swbl_out_if.source                      result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swbl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swbl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swbl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  swbl_pkg::swbl_cfg_t    cfg;
  swbl_pkg::swbl_item_t   item_q, item_d;
  swbl_pkg::swbl_result_t res_q, res_d, step_res;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   step;
  logic                   step_has_res;
  logic                   in_xfer;

  swbl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held item steps when the result register can take its result.
  assign step         = in_valid_q & (~out_valid_q | result_o.ready);
  assign item_i.ready = ~in_valid_q | step;
  assign in_xfer      = item_i.valid & item_i.ready;

  swbl_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .has_result_o (step_has_res),
    .result_o     (step_res)
  );

  // Input register.
  always_comb begin
    item_d     = item_q;
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d             = 1'b1;
      item_d.operation       = item_i.operation;
      item_d.image_size      = item_i.image_size;
      item_d.reply_block_low = item_i.reply_block_low;
      item_d.data_word0      = item_i.data_word0;
      item_d.data_word1      = item_i.data_word1;
      item_d.data_word2      = item_i.data_word2;
      item_d.data_word3      = item_i.data_word3;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register.
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = step_has_res;
      res_d       = step_res;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.event_kind    = res_q.event_kind;
  assign result_o.request_high  = res_q.request_high;
  assign result_o.request_low   = res_q.request_low;
  assign result_o.write_address = res_q.write_address;
  assign result_o.out_word0     = res_q.out_word0;
  assign result_o.out_word1     = res_q.out_word1;
  assign result_o.out_word2     = res_q.out_word2;
  assign result_o.out_word3     = res_q.out_word3;
  assign result_o.erase_pages   = res_q.erase_pages;

endmodule

/* design/swbl_cfg.sv */
// APB-style configuration registers of the block loader.
// Depends on swbl_pkg for the register map, reset values and swbl_cfg_t.
module swbl_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swbl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swbl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swbl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output swbl_pkg::swbl_cfg_t             cfg_o
);

  swbl_pkg::swbl_cfg_t cfg_q, cfg_d;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        swbl_pkg::REG_TIMEOUT_LIMIT: cfg_d.timeout_limit = pwdata[swbl_pkg::TICKS_W-1:0];
        swbl_pkg::REG_RETRY_LIMIT:   cfg_d.retry_limit   = pwdata[swbl_pkg::RETRY_W-1:0];
        swbl_pkg::REG_FLASH_BASE:    cfg_d.flash_base    = pwdata[swbl_pkg::WORD_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit <= swbl_pkg::TIMEOUT_RESET;
      cfg_q.retry_limit   <= swbl_pkg::RETRY_RESET;
      cfg_q.flash_base    <= swbl_pkg::BASE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux; addresses past the map read as zero.
  always_comb begin
    unique case (reg_idx)
      swbl_pkg::REG_TIMEOUT_LIMIT: prdata = 32'(cfg_q.timeout_limit);
      swbl_pkg::REG_RETRY_LIMIT:   prdata = 32'(cfg_q.retry_limit);
      swbl_pkg::REG_FLASH_BASE:    prdata = cfg_q.flash_base;
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/swbl_engine.sv */
// Loader engine: protocol state and the single-pass step from the held input
// item to the next result. Depends on swbl_pkg.
module swbl_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  swbl_pkg::swbl_item_t   item_i,
  input  swbl_pkg::swbl_cfg_t    cfg_i,
  output logic                   has_result_o,
  output swbl_pkg::swbl_result_t result_o
);

  typedef struct packed {
    logic                           loading;
    logic [swbl_pkg::BLOCK_W-1:0]   block_total;
    logic [swbl_pkg::BLOCK_W-1:0]   next_block;
    logic                           awaiting_reply;
    logic [swbl_pkg::TICKS_W-1:0]   wait_ticks;
    logic [swbl_pkg::RETRY_W-1:0]   retries;
  } swbl_state_t;

  swbl_state_t st_q, st_d;

  logic [swbl_pkg::SIZE_W:0]        pages_sum;
  logic [swbl_pkg::PAGES_W-1:0]     pages;
  logic [swbl_pkg::BLOCK_W-1:0]     total_new;
  logic [swbl_pkg::TICKS_W-1:0]     wait_inc;
  logic [swbl_pkg::RETRY_W-1:0]     retry_inc;
  logic                             all_sent;
  logic [swbl_pkg::WORD_W-1:0]      wr_addr;

  // Start arithmetic: erase page count (saturated) and rounded-up block total.
  assign pages_sum = (swbl_pkg::SIZE_W+1)'(item_i.image_size >> swbl_pkg::PAGE_SHIFT)
                     + (swbl_pkg::SIZE_W+1)'(1);
  assign pages     = (pages_sum > (swbl_pkg::SIZE_W+1)'(swbl_pkg::PAGES_MAX))
                     ? swbl_pkg::PAGES_MAX : pages_sum[swbl_pkg::PAGES_W-1:0];
  assign total_new = swbl_pkg::BLOCK_W'(item_i.image_size >> swbl_pkg::BLOCK_SHIFT)
                     + swbl_pkg::BLOCK_W'(|item_i.image_size[swbl_pkg::BLOCK_SHIFT-1:0]);

  // Saturating counters and shared comparisons.
  assign wait_inc  = (st_q.wait_ticks == '1) ? st_q.wait_ticks
                                             : st_q.wait_ticks + swbl_pkg::TICKS_W'(1);
  assign retry_inc = (st_q.retries == '1) ? st_q.retries
                                          : st_q.retries + swbl_pkg::RETRY_W'(1);
  assign all_sent  = (st_q.next_block == st_q.block_total);
  assign wr_addr   = cfg_i.flash_base
                     + (swbl_pkg::WORD_W'(st_q.next_block) << swbl_pkg::BLOCK_SHIFT);

  // One protocol step per held item.
  always_comb begin
    logic [swbl_pkg::TICKS_W-1:0] wait_v;
    logic [swbl_pkg::RETRY_W-1:0] retry_v;

    st_d         = st_q;
    has_result_o = 1'b0;
    result_o     = '0;
    wait_v       = wait_inc;
    retry_v      = st_q.retries;

    if (step_i) begin
      case (item_i.operation)
        swbl_pkg::OP_START: begin
          st_d.loading        = 1'b1;
          st_d.block_total    = total_new;
          st_d.next_block     = '0;
          st_d.awaiting_reply = 1'b0;
          st_d.wait_ticks     = '0;
          st_d.retries        = '0;
          has_result_o        = 1'b1;
          result_o.event_kind = swbl_pkg::EV_ERASE;
          result_o.erase_pages = pages;
        end
        swbl_pkg::OP_TICK: begin
          if (st_q.loading) begin
            if (all_sent) begin
              st_d.loading        = 1'b0;
              has_result_o        = 1'b1;
              result_o.event_kind = swbl_pkg::EV_DONE;
            end else if (!st_q.awaiting_reply) begin
              st_d.wait_ticks       = '0;
              st_d.awaiting_reply   = 1'b1;
              has_result_o          = 1'b1;
              result_o.event_kind   = swbl_pkg::EV_REQUEST;
              result_o.request_high = st_q.next_block[11:4];
              result_o.request_low  = st_q.next_block[3:0];
            end else begin
              // Count toward the timeout; a timeout frees a resend.
              if (wait_inc > cfg_i.timeout_limit) begin
                wait_v              = '0;
                st_d.awaiting_reply = 1'b0;
                retry_v             = retry_inc;
              end
              st_d.wait_ticks = wait_v;
              st_d.retries    = retry_v;
              if (retry_v > cfg_i.retry_limit) begin
                st_d.loading        = 1'b0;
                has_result_o        = 1'b1;
                result_o.event_kind = swbl_pkg::EV_ABORT;
              end
            end
          end
        end
        swbl_pkg::OP_RESPONSE: begin
          if (st_q.loading && !all_sent) begin
            if (item_i.reply_block_low != st_q.next_block[3:0]) begin
              // Wrong block echoed: ask again and count a retry.
              st_d.retries          = retry_inc;
              has_result_o          = 1'b1;
              result_o.event_kind   = swbl_pkg::EV_REQUEST;
              result_o.request_high = st_q.next_block[11:4];
              result_o.request_low  = st_q.next_block[3:0];
            end else begin
              st_d.next_block        = st_q.next_block + swbl_pkg::BLOCK_W'(1);
              st_d.awaiting_reply    = 1'b0;
              st_d.retries           = '0;
              has_result_o           = 1'b1;
              result_o.event_kind    = swbl_pkg::EV_WRITE;
              result_o.write_address = wr_addr;
              result_o.out_word0     = item_i.data_word0;
              result_o.out_word1     = item_i.data_word1;
              result_o.out_word2     = item_i.data_word2;
              result_o.out_word3     = item_i.data_word3;
            end
          end
        end
        default: begin
          st_d = st_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

/* tb/stop_and_wait_block_loader_core_tb.sv */
// Testbench for the stop-and-wait block loader: drives start, tick and response items,
// predicts every erase, request, write, finished and aborted event and checks them.
// Depends on swbl_pkg, swbl_if and stop_and_wait_block_loader_core.
module stop_and_wait_block_loader_core_tb;
  import swbl_pkg::*;

  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned MAX_IDLE        = 11;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS     = 160;
  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  swbl_in_if  item_if ();
  swbl_out_if result_if ();

  stop_and_wait_block_loader_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Register copies and loader state as the predictor sees them.
  logic [TICKS_W-1:0] cfg_timeout;
  logic [RETRY_W-1:0] cfg_retry;
  logic [WORD_W-1:0]  cfg_base;
  bit                 ld_active;
  logic [BLOCK_W-1:0] ld_total;
  logic [BLOCK_W-1:0] ld_next;
  bit                 ld_awaiting;
  logic [TICKS_W-1:0] ld_wait;
  logic [RETRY_W-1:0] ld_retries;

  swbl_result_t expected_events[$];

  bit          src_idle_en;
  bit          sink_idle_en;
  bit          hold_off_req;
  int unsigned items_sent;
  int unsigned items_acted;
  int unsigned events_checked;
  int unsigned writes_seen;
  int unsigned finishes_seen;
  int unsigned aborts_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Request event for the given block number.
  function automatic swbl_result_t request_event(input logic [BLOCK_W-1:0] blk);
    swbl_result_t ev;
    ev = '0;
    ev.event_kind   = EV_REQUEST;
    ev.request_high = blk[11:4];
    ev.request_low  = blk[3:0];
    return ev;
  endfunction

  // Advance the loader state by one item and queue the event it causes.
  // Returns 0 when the loader ignores the item.
  function automatic bit predict_loader_step(input swbl_item_t it);
    swbl_result_t ev;
    bit           emit;
    bit           acted;
    int unsigned  pages;
    ev    = '0;
    emit  = 1'b0;
    acted = 1'b0;
    case (it.operation)
      OP_START: begin
        pages = (it.image_size >> PAGE_SHIFT) + 1;
        if (pages > PAGES_MAX) pages = PAGES_MAX;
        ld_active   = 1'b1;
        ld_total    = BLOCK_W'((it.image_size + BLOCK_BYTES - 1) >> BLOCK_SHIFT);
        ld_next     = '0;
        ld_awaiting = 1'b0;
        ld_wait     = '0;
        ld_retries  = '0;
        ev.event_kind  = EV_ERASE;
        ev.erase_pages = pages[PAGES_W-1:0];
        emit  = 1'b1;
        acted = 1'b1;
      end
      OP_TICK: begin
        if (ld_active) begin
          acted = 1'b1;
          if (ld_next == ld_total) begin
            ld_active     = 1'b0;
            ev.event_kind = EV_DONE;
            emit          = 1'b1;
          end else if (!ld_awaiting) begin
            ld_wait     = '0;
            ld_awaiting = 1'b1;
            ev          = request_event(ld_next);
            emit        = 1'b1;
          end else begin
            // Count toward the timeout; a timeout frees a resend and costs a retry.
            if (ld_wait != '1) ld_wait++;
            if (ld_wait > cfg_timeout) begin
              ld_wait     = '0;
              ld_awaiting = 1'b0;
              if (ld_retries != '1) ld_retries++;
            end
            if (ld_retries > cfg_retry) begin
              ld_active     = 1'b0;
              ev.event_kind = EV_ABORT;
              emit          = 1'b1;
            end
          end
        end
      end
      OP_RESPONSE: begin
        if (ld_active && ld_next != ld_total) begin
          acted = 1'b1;
          emit  = 1'b1;
          if (it.reply_block_low != ld_next[NIBBLE_W-1:0]) begin
            if (ld_retries != '1) ld_retries++;
            ev = request_event(ld_next);
          end else begin
            ev.event_kind    = EV_WRITE;
            ev.write_address = cfg_base + {ld_next, 4'b0000};
            ev.out_word0     = it.data_word0;
            ev.out_word1     = it.data_word1;
            ev.out_word2     = it.data_word2;
            ev.out_word3     = it.data_word3;
            ld_next          = ld_next + 1'b1;
            ld_awaiting      = 1'b0;
            ld_retries       = '0;
          end
        end
      end
      default: ;
    endcase
    if (emit) expected_events.push_back(ev);
    return acted;
  endfunction

  function automatic swbl_item_t make_item(input logic [OP_W-1:0]     op,
                                           input logic [SIZE_W-1:0]   size,
                                           input logic [NIBBLE_W-1:0] low);
    swbl_item_t it;
    it.operation       = op;
    it.image_size      = size;
    it.reply_block_low = low;
    it.data_word0      = $urandom;
    it.data_word1      = $urandom;
    it.data_word2      = $urandom;
    it.data_word3      = $urandom;
    return it;
  endfunction

  // Mostly small images so that loads finish; now and then a large one.
  function automatic logic [SIZE_W-1:0] random_image_size();
    case ($urandom_range(0, 19))
      0:       return SIZE_W'($urandom_range(0, 20'hFFFFF));
      1:       return SIZE_W'($urandom_range(0, 4096));
      default: return SIZE_W'($urandom_range(0, 96));
    endcase
  endfunction

  // Offer one item after a random gap and predict it once the transfer happens.
  task automatic offer_item(input swbl_item_t it);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.operation       <= it.operation;
    item_if.image_size      <= it.image_size;
    item_if.reply_block_low <= it.reply_block_low;
    item_if.data_word0      <= it.data_word0;
    item_if.data_word1      <= it.data_word1;
    item_if.data_word2      <= it.data_word2;
    item_if.data_word3      <= it.data_word3;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
    if (predict_loader_step(it)) items_acted++;
  endtask

  // Stop offering, collect every outstanding event and let the pipeline empty.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase until pready, then an idle phase.
  task automatic write_register(input logic [1:0] idx, input logic [WORD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_TIMEOUT_LIMIT: cfg_timeout = value[TICKS_W-1:0];
      REG_RETRY_LIMIT:   cfg_retry   = value[RETRY_W-1:0];
      REG_FLASH_BASE:    cfg_base    = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [TICKS_W-1:0] timeout,
                            input logic [RETRY_W-1:0] retry,
                            input logic [WORD_W-1:0]  base);
    write_register(REG_TIMEOUT_LIMIT, WORD_W'(timeout));
    write_register(REG_RETRY_LIMIT, WORD_W'(retry));
    write_register(REG_FLASH_BASE, base);
  endtask

  // Ticks, responses and the unused code while no load runs are all dropped.
  task automatic test_idle_items();
    swbl_item_t it;
    offer_item(make_item(OP_TICK, '1, '1));
    offer_item(make_item(OP_RESPONSE, '0, '0));
    it = make_item(OP_UNUSED, '1, '1);
    it.data_word0 = '1;
    it.data_word1 = '1;
    it.data_word2 = '1;
    it.data_word3 = '1;
    offer_item(it);
    wait_idle();
  endtask

  // Empty image, largest image, restart during a load, mismatch, write without a
  // pending request, response after the last block and the finishing tick.
  task automatic test_load_and_restart();
    swbl_item_t it;
    offer_item(make_item(OP_START, '0, '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_START, '1, '0));
    offer_item(make_item(OP_START, SIZE_W'(17), '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_RESPONSE, '0, '1));
    it = make_item(OP_RESPONSE, '1, '0);
    it.data_word0 = '1;
    it.data_word1 = '1;
    it.data_word2 = '1;
    it.data_word3 = '1;
    offer_item(it);
    it = make_item(OP_RESPONSE, '0, NIBBLE_W'(1));
    it.data_word0 = '0;
    it.data_word1 = '0;
    it.data_word2 = '0;
    it.data_word3 = '0;
    offer_item(it);
    offer_item(make_item(OP_RESPONSE, '0, NIBBLE_W'(2)));
    offer_item(make_item(OP_TICK, '0, '0));
    wait_idle();
  endtask

  // Zero limits: the first unanswered tick aborts; the write address wraps.
  task automatic test_timeout_abort();
    set_config('0, '0, '1);
    offer_item(make_item(OP_START, SIZE_W'(16), '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_START, SIZE_W'(32), '0));
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_RESPONSE, '0, '0));
    offer_item(make_item(OP_RESPONSE, '0, NIBBLE_W'(1)));
    offer_item(make_item(OP_TICK, '0, '0));
    wait_idle();
  endtask

  // Limits at the counter maximum: unanswered ticks never time out, and the
  // retry counter saturates without tripping.
  task automatic test_counter_ceilings();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config('1, '1, 32'h0001_0000);
    offer_item(make_item(OP_START, SIZE_W'(32), '0));
    offer_item(make_item(OP_TICK, '0, '0));
    repeat (40) offer_item(make_item(OP_TICK, '0, '0));
    repeat (260) begin
      offer_item(make_item(OP_RESPONSE, '0,
                           ld_next[NIBBLE_W-1:0] + NIBBLE_W'($urandom_range(1, 15))));
    end
    offer_item(make_item(OP_TICK, '0, '0));
    offer_item(make_item(OP_RESPONSE, '0, ld_next[NIBBLE_W-1:0]));
    wait_idle();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while starts keep coming.
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    repeat (24) offer_item(make_item(OP_START, random_image_size(), '0));
    wait_idle();
    src_idle_en  = 1'b1;
  endtask

  // Peer behavior: mostly well-formed replies, with lost replies, wrong block
  // numbers, restarts and the unused code mixed in.
  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned first;
    int unsigned roll;
    swbl_item_t  it;
    first = items_acted;
    while (items_acted - first < n_items) begin
      if ($urandom_range(0, 47) == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      it   = make_item(OP_TICK, SIZE_W'($urandom), NIBBLE_W'($urandom));
      if (roll < 2 || (!ld_active && roll >= 20)) begin
        it.operation  = OP_START;
        it.image_size = random_image_size();
      end else if (roll < 6) begin
        it.operation = (roll < 4) ? OP_UNUSED : OP_RESPONSE;
      end else if (roll < (ld_awaiting ? 60 : 25)) begin
        it.operation       = OP_RESPONSE;
        it.reply_block_low = ld_next[NIBBLE_W-1:0];
      end else if (roll < (ld_awaiting ? 70 : 30)) begin
        it.operation       = OP_RESPONSE;
        it.reply_block_low = ld_next[NIBBLE_W-1:0] + NIBBLE_W'($urandom_range(1, 15));
      end
      offer_item(it);
    end
    wait_idle();
  endtask

  task automatic test_random_loads();
    set_config('0, '0, '1);
    run_random_traffic(PHASE_ITEMS);
    set_config('1, '1, '0);
    run_random_traffic(PHASE_ITEMS);
    repeat (2) begin
      set_config(TICKS_W'($urandom_range(0, 6)), RETRY_W'($urandom_range(0, 4)), $urandom);
      run_random_traffic(PHASE_ITEMS);
    end
    set_config(TIMEOUT_RESET, RETRY_RESET, BASE_RESET);
    run_random_traffic(PHASE_ITEMS);
  endtask

  // Result receiver: random ready gaps, plus one long hold-off on request.
  initial begin : result_receiver
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = sink_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Check each result transfer against the oldest expected event.
  always @(posedge clk_i) begin : check_events
    swbl_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event: expected none, actual kind %0h", $time,
                 result_if.event_kind);
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        if (want.event_kind == EV_WRITE) writes_seen++;
        if (want.event_kind == EV_DONE)  finishes_seen++;
        if (want.event_kind == EV_ABORT) aborts_seen++;
        compare_field("event_kind", want.event_kind, result_if.event_kind);
        compare_field("request_high", want.request_high, result_if.request_high);
        compare_field("request_low", want.request_low, result_if.request_low);
        compare_field("write_address", want.write_address, result_if.write_address);
        compare_field("out_word0", want.out_word0, result_if.out_word0);
        compare_field("out_word1", want.out_word1, result_if.out_word1);
        compare_field("out_word2", want.out_word2, result_if.out_word2);
        compare_field("out_word3", want.out_word3, result_if.out_word3);
        compare_field("erase_pages", want.erase_pages, result_if.erase_pages);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d events outstanding", $time,
               quiet_cycles, expected_events.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    item_if.valid           = 1'b0;
    item_if.operation       = '0;
    item_if.image_size      = '0;
    item_if.reply_block_low = '0;
    item_if.data_word0      = '0;
    item_if.data_word1      = '0;
    item_if.data_word2      = '0;
    item_if.data_word3      = '0;
    result_if.ready         = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    cfg_timeout             = TIMEOUT_RESET;
    cfg_retry               = RETRY_RESET;
    cfg_base                = BASE_RESET;
    ld_active               = 1'b0;
    ld_total                = '0;
    ld_next                 = '0;
    ld_awaiting             = 1'b0;
    ld_wait                 = '0;
    ld_retries              = '0;
    src_idle_en             = 1'b1;
    sink_idle_en            = 1'b1;
    hold_off_req            = 1'b0;
    items_sent              = 0;
    items_acted             = 0;
    events_checked          = 0;
    writes_seen             = 0;
    finishes_seen           = 0;
    aborts_seen             = 0;
    mismatches              = 0;
    quiet_cycles            = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_items();
    test_load_and_restart();
    test_timeout_abort();
    test_counter_ceilings();
    test_output_backpressure();
    test_random_loads();
    wait_idle();

    $display("Sent %0d items (%0d acted on), checked %0d events: %0d writes, %0d finished,",
             items_sent, items_acted, events_checked, writes_seen, finishes_seen);
    $display("%0d aborted, over register settings from zero limits to saturated counters.",
             aborts_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
